FILE: rtl/cpl_pkg.sv
// shared types, codes and defaults for the compacting point list
package cpl_pkg;

    localparam int CAP_DEFAULT = 16;

    // command codes
    localparam logic [2:0] CMD_APPEND    = 3'd0;
    localparam logic [2:0] CMD_REM_FIRST = 3'd1;
    localparam logic [2:0] CMD_REM_LAST  = 3'd2;
    localparam logic [2:0] CMD_REM_AT    = 3'd3;
    localparam logic [2:0] CMD_REM_X     = 3'd4;
    localparam logic [2:0] CMD_FIND_Y    = 3'd5;
    localparam logic [2:0] CMD_CLEAR     = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOSLOT   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [3:0]         slot;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         length;
        logic [4:0]         removed_count;
        logic signed [15:0] found_x;
        logic signed [15:0] found_y;
        logic [3:0]         found_slot;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_point;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_LOAD   = 3'd1,
        CELL_MARK   = 3'd2,
        CELL_SORT   = 3'd3,
        CELL_ROTATE = 3'd4
    } t_cell_op;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        t_cell_op           op;
        logic               phase;
        logic [2:0]         cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [3:0]         slot;
    } t_cell_ctrl;

endpackage

FILE: rtl/cpl_cell.sv
// one list entry: point storage, removal marking and neighbor exchange
module cpl_cell #(
    parameter int CAPACITY = cpl_pkg::CAP_DEFAULT,
    parameter int IDX      = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cpl_pkg::t_cell_ctrl              i_ctrl,
    input  logic [$clog2(CAPACITY+1)-1:0]    i_count,
    input  logic                             i_left_live,
    input  logic                             i_right_live,
    input  cpl_pkg::t_point                  i_right_pt,
    output cpl_pkg::t_point                  o_pt,
    output logic                             o_live,
    output logic                             o_kill
);
    import cpl_pkg::*;

    localparam int CW = $clog2(CAPACITY+1);
    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_C1 = CW'(IDX + 1);
    localparam logic ODD = 1'(IDX % 2);

    t_point r_pt;
    logic   r_live;
    logic   in_range;
    logic   is_left;

    assign in_range = IDX_C < i_count;
    assign is_left  = (ODD == i_ctrl.phase);

    always_comb begin
        o_kill = 1'b0;
        unique case (i_ctrl.cmd)
            CMD_REM_FIRST: o_kill = in_range && (IDX == 0);
            CMD_REM_LAST:  o_kill = in_range && (IDX_C1 == i_count);
            CMD_REM_AT:    o_kill = in_range && (32'(i_ctrl.slot) == IDX);
            CMD_REM_X:     o_kill = in_range && (r_pt.x == i_ctrl.pos_x);
            default:       o_kill = 1'b0;
        endcase
    end

    // payload
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            CELL_LOAD: begin
                if (IDX_C == i_count) begin
                    r_pt.x <= i_ctrl.pos_x;
                    r_pt.y <= i_ctrl.pos_y;
                end
            end
            CELL_SORT: begin
                // a hole on the left of its pair pulls the live entry down
                if (is_left && !r_live && i_right_live) begin
                    r_pt <= i_right_pt;
                end
            end
            CELL_ROTATE: r_pt <= i_right_pt;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            unique case (i_ctrl.op)
                CELL_MARK: r_live <= in_range && !o_kill;
                CELL_SORT: begin
                    if (is_left) begin
                        if (!r_live && i_right_live) begin
                            r_live <= 1'b1;
                        end
                    end else if (r_live && !i_left_live) begin
                        r_live <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_pt   = r_pt;
    assign o_live = r_live;

endmodule

FILE: rtl/compacting_point_list.sv
// compacting point list: sequencer, result register and a row of entry cells
// append, clear, failed commands and code 7: straight from acceptance to the done state
// remove first/last/at index/matching x: a mark step, then an odd-even pass over the cells
// find y: one full rotation of the cells past cell 0
// one command at a time; the next is taken the cycle after the result is registered
// sync active-low reset empties the list and clears the handshake; point storage is not reset
module compacting_point_list #(
    parameter int CAPACITY = cpl_pkg::CAP_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cpl_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cpl_pkg::t_out_item  o_out_data
);
    import cpl_pkg::*;

    localparam int CW = $clog2(CAPACITY+1);
    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MARK = 5'b00010,
        S_SORT = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state             r_state;
    logic [2:0]         r_cmd;
    logic signed [15:0] r_px;
    logic signed [15:0] r_py;
    logic [3:0]         r_slot;
    logic [2:0]         r_status;
    logic [CW-1:0]      r_removed;
    logic [CW-1:0]      r_count;
    logic [IW-1:0]      r_cnt;
    logic [CAPACITY-1:0] r_kill;
    logic               r_found;
    logic signed [15:0] r_fx;
    logic signed [15:0] r_fy;
    logic [IW-1:0]      r_fslot;
    logic               r_out_valid;
    t_out_item          r_out;

    t_cell_ctrl          cell_ctrl;
    t_point              cell_pt   [CAPACITY];
    logic [CAPACITY-1:0] cell_live;
    logic [CAPACITY-1:0] cell_kill;

    logic          in_acc;
    logic          slot_free;
    logic          finish;
    logic          slot_ok;
    logic [2:0]    n_status;
    t_state        n_state_acc;
    logic [CW-1:0] n_count;
    logic [CW-1:0] n_removed;
    logic [31:0]   len_w;
    logic [31:0]   rem_w;
    logic [31:0]   fslot_w;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign finish     = (r_state == S_DONE) && slot_free;
    assign slot_ok    = 32'(i_in_data.slot) < 32'(r_count);

    // status known at acceptance, and the route through the sequencer
    always_comb begin
        n_status    = ST_OK;
        n_state_acc = S_DONE;
        unique case (i_in_data.cmd)
            CMD_APPEND: begin
                if (r_count == CW'(CAPACITY)) n_status = ST_FULL;
            end
            CMD_REM_FIRST, CMD_REM_LAST: begin
                if (r_count == '0) n_status = ST_EMPTY;
                else n_state_acc = S_MARK;
            end
            CMD_REM_AT: begin
                if (!slot_ok) n_status = ST_NOSLOT;
                else n_state_acc = S_MARK;
            end
            CMD_REM_X:  n_state_acc = S_MARK;
            CMD_FIND_Y: begin
                n_status    = ST_NOTFOUND;
                n_state_acc = S_SCAN;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_removed = r_removed;
        unique case (r_cmd)
            CMD_APPEND: begin
                if (r_status == ST_OK) n_count = r_count + CW'(1);
            end
            CMD_REM_FIRST, CMD_REM_LAST, CMD_REM_AT, CMD_REM_X: begin
                n_count = r_count - r_removed;
            end
            CMD_CLEAR: begin
                n_count   = '0;
                n_removed = r_count;
            end
            default: ;
        endcase
    end

    assign len_w   = 32'(n_count);
    assign rem_w   = 32'(n_removed);
    assign fslot_w = 32'(r_fslot);

    always_comb begin
        cell_ctrl.phase = r_cnt[0];
        cell_ctrl.cmd   = r_cmd;
        cell_ctrl.pos_x = r_px;
        cell_ctrl.pos_y = r_py;
        cell_ctrl.slot  = r_slot;
        cell_ctrl.op    = CELL_HOLD;
        unique case (r_state)
            S_MARK: cell_ctrl.op = CELL_MARK;
            S_SORT: cell_ctrl.op = CELL_SORT;
            S_SCAN: cell_ctrl.op = CELL_ROTATE;
            S_DONE: begin
                if (slot_free && (r_cmd == CMD_APPEND) && (r_status == ST_OK)) begin
                    cell_ctrl.op = CELL_LOAD;
                end
            end
            default: cell_ctrl.op = CELL_HOLD;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic   left_live;
            logic   right_live;
            t_point right_pt;
            if (g == 0) begin : g_first
                assign left_live = 1'b1;
            end else begin : g_mid_l
                assign left_live = cell_live[g-1];
            end
            if (g == CAPACITY-1) begin : g_last
                // the row closes on itself for rotation; no live right neighbor in a sort
                assign right_live = 1'b0;
                assign right_pt   = cell_pt[0];
            end else begin : g_mid_r
                assign right_live = cell_live[g+1];
                assign right_pt   = cell_pt[g+1];
            end
            cpl_cell #(
                .CAPACITY (CAPACITY),
                .IDX      (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (cell_ctrl),
                .i_count      (r_count),
                .i_left_live  (left_live),
                .i_right_live (right_live),
                .i_right_pt   (right_pt),
                .o_pt         (cell_pt[g]),
                .o_live       (cell_live[g]),
                .o_kill       (cell_kill[g])
            );
        end
    endgenerate

    // command payload and working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd     <= i_in_data.cmd;
            r_px      <= i_in_data.pos_x;
            r_py      <= i_in_data.pos_y;
            r_slot    <= i_in_data.slot;
            r_fx      <= '0;
            r_fy      <= '0;
            r_fslot   <= '0;
        end
        unique case (r_state)
            S_MARK: r_kill <= cell_kill;
            S_SORT: r_kill <= r_kill >> 1;
            S_SCAN: begin
                if (!r_found && (32'(r_cnt) < 32'(r_count)) && (cell_pt[0].y == r_py)) begin
                    r_fx    <= cell_pt[0].x;
                    r_fy    <= cell_pt[0].y;
                    r_fslot <= r_cnt;
                end
            end
            default: ;
        endcase
        if (finish) begin
            r_out.status        <= r_status;
            r_out.length        <= len_w[4:0];
            r_out.removed_count <= rem_w[4:0];
            r_out.found_x       <= r_found ? r_fx : 16'sd0;
            r_out.found_y       <= r_found ? r_fy : 16'sd0;
            r_out.found_slot    <= r_found ? fslot_w[3:0] : 4'd0;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_removed   <= '0;
            r_status    <= ST_OK;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (finish) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_status  <= n_status;
                        r_removed <= '0;
                        r_found   <= 1'b0;
                        r_cnt     <= '0;
                        r_state   <= n_state_acc;
                    end
                end
                S_MARK: begin
                    r_cnt   <= '0;
                    r_state <= S_SORT;
                end
                S_SORT: begin
                    r_removed <= r_removed + CW'(r_kill[0]);
                    r_cnt     <= r_cnt + IW'(1);
                    if (r_cnt == IW'(CAPACITY-1)) r_state <= S_DONE;
                end
                S_SCAN: begin
                    if (!r_found && (32'(r_cnt) < 32'(r_count)) && (cell_pt[0].y == r_py)) begin
                        r_found  <= 1'b1;
                        r_status <= ST_OK;
                    end
                    r_cnt <= r_cnt + IW'(1);
                    if (r_cnt == IW'(CAPACITY-1)) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_count     <= n_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: test/tb_compacting_point_list.sv
// self-checking testbench for the compacting point list
`timescale 1ns / 100ps

module tb_compacting_point_list;

    import cpl_pkg::*;

    localparam int         CAP          = CAP_DEFAULT;
    localparam int         RANDOM_ITEMS = 925;
    localparam int         QUIET_TAIL   = 150;
    localparam int         DRAIN_CYCLES = CAP + 8;
    localparam int         STALL_LIMIT  = 2000;
    localparam logic [2:0] CMD_UNUSED   = 3'd7;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    // shadow copy of the list
    logic signed [15:0] list_x [CAP];
    logic signed [15:0] list_y [CAP];
    int                 list_len = 0;

    t_out_item expected_results [$];

    bit idle_on      = 1'b1;
    int fail_count   = 0;
    int quiet_cycles = 0;
    int sent_count   = 0;
    int find_hits    = 0;
    int full_rejects = 0;
    int removed_sum  = 0;
    int peak_len     = 0;

    compacting_point_list #(
        .CAPACITY(CAP)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // applies one command to the shadow list and returns the result it should give
    function automatic t_out_item list_apply(input t_in_item item);
        t_out_item res;
        int        idx;
        int        kept;
        int        gap_at;
        res        = '0;
        res.status = ST_OK;
        gap_at     = -1;
        case (item.cmd)
            CMD_APPEND: begin
                if (list_len >= CAP) begin
                    res.status = ST_FULL;
                end else begin
                    list_x[list_len] = item.pos_x;
                    list_y[list_len] = item.pos_y;
                    list_len++;
                end
            end
            CMD_REM_FIRST, CMD_REM_LAST: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    gap_at = (item.cmd == CMD_REM_FIRST) ? 0 : list_len - 1;
                end
            end
            CMD_REM_AT: begin
                if (int'(item.slot) >= list_len) begin
                    res.status = ST_NOSLOT;
                end else begin
                    gap_at = int'(item.slot);
                end
            end
            CMD_REM_X: begin
                kept = 0;
                for (idx = 0; idx < list_len; idx++) begin
                    if (list_x[idx] != item.pos_x) begin
                        list_x[kept] = list_x[idx];
                        list_y[kept] = list_y[idx];
                        kept++;
                    end
                end
                res.removed_count = 5'(list_len - kept);
                list_len = kept;
            end
            CMD_FIND_Y: begin
                res.status = ST_NOTFOUND;
                for (idx = 0; idx < list_len; idx++) begin
                    if (list_y[idx] == item.pos_y) begin
                        res.status     = ST_OK;
                        res.found_x    = list_x[idx];
                        res.found_y    = list_y[idx];
                        res.found_slot = 4'(idx);
                        break;
                    end
                end
            end
            CMD_CLEAR: begin
                res.removed_count = 5'(list_len);
                list_len = 0;
            end
            default: begin
            end
        endcase
        // close the gap left by a single removal
        if (gap_at >= 0) begin
            for (idx = gap_at; idx + 1 < list_len; idx++) begin
                list_x[idx] = list_x[idx + 1];
                list_y[idx] = list_y[idx + 1];
            end
            list_len--;
            res.removed_count = 5'd1;
        end
        res.length = 5'(list_len);
        return res;
    endfunction

    function automatic t_in_item make_item(input logic [2:0] cmd, input logic signed [15:0] x,
                                           input logic signed [15:0] y, input logic [3:0] slot);
        t_in_item item;
        item.cmd   = cmd;
        item.pos_x = x;
        item.pos_y = y;
        item.slot  = slot;
        return item;
    endfunction

    // half the time small values from -2 to 2 so that matches happen, else extremes or full range
    function automatic logic signed [15:0] random_coord();
        logic signed [15:0] v;
        case ($urandom_range(0, 3))
            0:       v = 16'($urandom);
            1:       v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: v = 16'($urandom_range(0, 4)) - 16'sd2;
        endcase
        return v;
    endfunction

    function automatic t_in_item random_item();
        t_in_item item;
        int       append_weight;
        item.pos_x = random_coord();
        item.pos_y = random_coord();
        item.slot  = 4'($urandom_range(0, 15));
        append_weight = (list_len < CAP) ? 55 : 30;
        if ($urandom_range(0, 99) < append_weight) begin
            item.cmd = CMD_APPEND;
        end else begin
            case ($urandom_range(0, 12))
                0, 1:     item.cmd = CMD_REM_FIRST;
                2, 3:     item.cmd = CMD_REM_LAST;
                4, 5, 6:  item.cmd = CMD_REM_AT;
                7, 8:     item.cmd = CMD_REM_X;
                9, 10, 11: item.cmd = CMD_FIND_Y;
                default:  item.cmd = $urandom_range(0, 1) ? CMD_CLEAR : CMD_UNUSED;
            endcase
        end
        // aim match and index commands at stored entries most of the time
        if (list_len > 0 && $urandom_range(0, 3) != 0) begin
            if (item.cmd == CMD_REM_X) begin
                item.pos_x = list_x[$urandom_range(0, list_len - 1)];
            end else if (item.cmd == CMD_FIND_Y) begin
                item.pos_y = list_y[$urandom_range(0, list_len - 1)];
            end else if (item.cmd == CMD_REM_AT) begin
                item.slot = 4'($urandom_range(0, list_len - 1));
            end
        end
        return item;
    endfunction

    task automatic send_cmd(input t_in_item item);
        int        gap;
        t_out_item res;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        res = list_apply(item);
        expected_results.push_back(res);
        sent_count++;
        removed_sum += int'(res.removed_count);
        if (item.cmd == CMD_FIND_Y && res.status == ST_OK) find_hits++;
        if (res.status == ST_FULL) full_rejects++;
        if (list_len > peak_len) peak_len = list_len;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_empty_list();
        send_cmd(make_item(CMD_REM_FIRST, 16'sd0, 16'sd0, 4'd0));
        send_cmd(make_item(CMD_REM_LAST, 16'sd0, 16'sd0, 4'd0));
        send_cmd(make_item(CMD_REM_AT, 16'sd0, 16'sd0, 4'd0));
        send_cmd(make_item(CMD_FIND_Y, 16'sd0, 16'sd0, 4'd0));
        send_cmd(make_item(CMD_REM_X, 16'sd0, 16'sd0, 4'd0));
        send_cmd(make_item(CMD_UNUSED, 16'sh7fff, 16'sh8000, 4'hf));
    endtask

    task automatic test_fill_to_capacity();
        int                 i;
        logic signed [15:0] x;
        logic signed [15:0] y;
        for (i = 0; i < CAP; i++) begin
            // odd entries share the most negative x, two entries share y = 100
            x = i[0] ? 16'sh8000 : 16'(i);
            if (i == CAP - 1)       y = 16'sh7fff;
            else if (i == CAP - 2)  y = 16'sh8000;
            else if (i % 6 == 3)    y = 16'sd100;
            else                    y = -16'(i);
            send_cmd(make_item(CMD_APPEND, x, y, 4'(i)));
        end
        send_cmd(make_item(CMD_APPEND, 16'sh7fff, 16'sh8000, 4'hf));
    endtask

    task automatic test_full_list_ops();
        send_cmd(make_item(CMD_FIND_Y, 16'sd0, 16'sd100, 4'd0));
        send_cmd(make_item(CMD_REM_AT, 16'sd0, 16'sd0, 4'hf));
        send_cmd(make_item(CMD_REM_X, 16'sh8000, 16'sd0, 4'd0));
        send_cmd(make_item(CMD_REM_LAST, 16'sd0, 16'sd0, 4'd0));
        send_cmd(make_item(CMD_CLEAR, 16'sd0, 16'sd0, 4'd0));
    endtask

    task automatic test_random_mix(input int n_items);
        int k;
        for (k = 0; k < n_items; k++) begin
            if (k % 50 == 0) begin
                idle_on = (k < n_items - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            end
            send_cmd(random_item());
        end
    endtask

    // result side back-pressure
    initial begin : drive_out_ready
        int stall;
        forever begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 10);
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected: %h", out_data);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(out_data.status));
                check_field("length", 32'(want.length), 32'(out_data.length));
                check_field("removed_count", 32'(want.removed_count),
                            32'(out_data.removed_count));
                check_field("found_x", 32'(want.found_x), 32'(out_data.found_x));
                check_field("found_y", 32'(want.found_y), 32'(out_data.found_y));
                check_field("found_slot", 32'(want.found_slot), 32'(out_data.found_slot));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT) @(posedge clk);
        $error("no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_fill_to_capacity();
        test_full_list_ops();
        test_random_mix(RANDOM_ITEMS);
        drain_results();
        $display("ran %0d commands, peak length %0d, %0d entries removed", sent_count,
                 peak_len, removed_sum);
        $display("%0d successful finds, %0d appends rejected on a full list", find_hits,
                 full_rejects);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
